>>> src/gcs_pkg.sv
// shared constants and types of the gradient centre score block
`default_nettype none
package gcs_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_GRADIENTS = 4096;

	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int GRAD_W = 16;
	localparam int CTR_W = 6;
	localparam int SCORE_W = 41;
	localparam int DIM_W = 9;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = $clog2(MAX_GRADIENTS);
	localparam int CNT_W = ADDR_W + 1;
	localparam int ENTRY_W = COL_W + ROW_W + 2 * GRAD_W;

	localparam int POS_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int DX_W = ((POS_MAX_W > CTR_W) ? POS_MAX_W : CTR_W) + 1;
	localparam int PROD_W = DX_W + GRAD_W;
	localparam int DOT_W = PROD_W + 1;
	localparam int DPOS_W = DOT_W - 1;
	localparam int SQ_W = 2 * DPOS_W;
	localparam int MAG_W = 2 * DX_W + 1;
	localparam int ACC_W = ((SQ_W > SCORE_W) ? SQ_W : SCORE_W) + 1;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} entry_t;
endpackage
`default_nettype wire

>>> src/gcs_if.sv
// channel interfaces: input word and result word
`default_nettype none
interface gcs_in_if;
	logic valid;
	logic ready;
	logic func;
	logic frame_start;
	logic signed [gcs_pkg::GRAD_W-1:0] grad_x;
	logic signed [gcs_pkg::GRAD_W-1:0] grad_y;
	logic [gcs_pkg::CTR_W-1:0] center_x;
	logic [gcs_pkg::CTR_W-1:0] center_y;
	modport source (output valid, func, frame_start, grad_x, grad_y, center_x, center_y,
		input ready);
	modport sink (input valid, func, frame_start, grad_x, grad_y, center_x, center_y,
		output ready);
endinterface

interface gcs_out_if;
	logic valid;
	logic ready;
	logic [gcs_pkg::SCORE_W-1:0] score;
	modport source (output valid, score, input ready);
	modport sink (input valid, score, output ready);
endinterface
`default_nettype wire

>>> src/gradient_center_score_core.sv
// gradient centre score: gradient store, query walk pipeline and divider
//
// Usage: words arrive on in_ch. A load word (func 0) carries one gradient
// pixel in raster order; frame_start clears the store count and the
// position first. Loads may follow back to back while idle. A pixel with
// a non-zero gradient inside the frame is written to the store while it has room.
// A query word (func 1) names a centre; the block then reads the store
// one entry per cycle through a pipeline of four stages and a divider of
// one quotient bit per stage (SQ_W stages), and returns one score word on
// out_ch. A query's duration is set by the single store read port and the
// divider depth; in_ch is not ready meanwhile. The score word is held in
// an output register until out_ch takes it; while it waits no new word is
// accepted. image_width and image_height are written on the cfg port; the
// user must do so only while idle, the block does not enforce it. Reset
// clears position, count and all valid flags and sets the size registers
// to 64; the store is not cleared, entries beyond the count are never read.
`default_nettype none
module gradient_center_score_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [gcs_pkg::CFG_W-1:0] cfg_wdata,
	gcs_in_if.sink in_ch,
	gcs_out_if.source out_ch
);
	gcs_pkg::state_t state_q;
	logic [gcs_pkg::CFG_W-1:0] width_q, height_q;
	logic [gcs_pkg::COL_W:0] col_q;
	logic [gcs_pkg::ROW_W:0] row_q;
	logic [gcs_pkg::CNT_W-1:0] cnt_q, rd_idx_q;
	logic [gcs_pkg::CTR_W-1:0] cx_q, cy_q;
	logic [gcs_pkg::SCORE_W-1:0] sum_q;

	gcs_pkg::entry_t mem [gcs_pkg::MAX_GRADIENTS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= gcs_pkg::CFG_W'(64);
			height_q <= gcs_pkg::CFG_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcs_pkg::REG_WIDTH: width_q <= cfg_wdata;
				gcs_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [gcs_pkg::DIM_W-1:0] w_eff, h_eff;
	always_comb begin
		if (width_q == '0) w_eff = gcs_pkg::DIM_W'(1);
		else if (gcs_pkg::DIM_W'(width_q) > gcs_pkg::DIM_W'(gcs_pkg::MAX_WIDTH))
			w_eff = gcs_pkg::DIM_W'(gcs_pkg::MAX_WIDTH);
		else w_eff = gcs_pkg::DIM_W'(width_q);
		if (height_q == '0) h_eff = gcs_pkg::DIM_W'(1);
		else if (gcs_pkg::DIM_W'(height_q) > gcs_pkg::DIM_W'(gcs_pkg::MAX_HEIGHT))
			h_eff = gcs_pkg::DIM_W'(gcs_pkg::MAX_HEIGHT);
		else h_eff = gcs_pkg::DIM_W'(height_q);
	end

	logic in_acc, load_acc, query_acc;
	assign in_ch.ready = (state_q == gcs_pkg::ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign load_acc = in_acc && !in_ch.func;
	assign query_acc = in_acc && in_ch.func;

	// raster position tracking for a load word
	logic [gcs_pkg::COL_W:0] c0, c1, c2, c_nx;
	logic [gcs_pkg::ROW_W:0] r0, r1, r_nx;
	logic [gcs_pkg::CNT_W-1:0] n0, n_nx;
	logic in_frame, store_en;
	always_comb begin
		c0 = in_ch.frame_start ? '0 : col_q;
		r0 = in_ch.frame_start ? '0 : row_q;
		n0 = in_ch.frame_start ? '0 : cnt_q;
		c1 = c0;
		r1 = r0;
		if (gcs_pkg::DIM_W'(c0) >= w_eff) begin
			c1 = '0;
			if (r0 < (gcs_pkg::ROW_W+1)'(gcs_pkg::MAX_HEIGHT)) r1 = r0 + 1'b1;
		end
		in_frame = gcs_pkg::DIM_W'(r1) < h_eff;
		store_en = in_frame && (in_ch.grad_x != '0 || in_ch.grad_y != '0)
			&& n0 < gcs_pkg::CNT_W'(gcs_pkg::MAX_GRADIENTS);
		n_nx = store_en ? n0 + 1'b1 : n0;
		c_nx = c1;
		r_nx = r1;
		c2 = c1 + 1'b1;
		if (in_frame) begin
			if (gcs_pkg::DIM_W'(c2) >= w_eff) begin
				c_nx = '0;
				if (r1 < (gcs_pkg::ROW_W+1)'(gcs_pkg::MAX_HEIGHT)) r_nx = r1 + 1'b1;
			end else begin
				c_nx = c2;
			end
		end
	end

	// position and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (load_acc) begin
			col_q <= c_nx;
			row_q <= r_nx;
			cnt_q <= n_nx;
		end
	end

	// query walk control
	logic issue, busy, walk_done;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [gcs_pkg::SQ_W-1:0] v_d;
	assign issue = (state_q == gcs_pkg::ST_WALK) && (rd_idx_q < cnt_q);
	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || (|v_d);
	assign walk_done = (state_q == gcs_pkg::ST_WALK) && !issue && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcs_pkg::ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				gcs_pkg::ST_IDLE: if (query_acc) begin
					state_q <= gcs_pkg::ST_WALK;
					rd_idx_q <= '0;
				end
				gcs_pkg::ST_WALK: begin
					if (issue) rd_idx_q <= rd_idx_q + 1'b1;
					if (walk_done) state_q <= gcs_pkg::ST_DONE;
				end
				gcs_pkg::ST_DONE: if (out_ch.ready) state_q <= gcs_pkg::ST_IDLE;
				default: state_q <= gcs_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			cx_q <= in_ch.center_x;
			cy_q <= in_ch.center_y;
		end
	end

	// gradient store: written on load, read during walk
	gcs_pkg::entry_t rd_s1;
	always_ff @(posedge clk) begin
		if (load_acc && store_en)
			mem[n0[gcs_pkg::ADDR_W-1:0]] <= '{col: c1[gcs_pkg::COL_W-1:0],
				row: r1[gcs_pkg::ROW_W-1:0], gx: in_ch.grad_x, gy: in_ch.grad_y};
		if (issue) rd_s1 <= mem[rd_idx_q[gcs_pkg::ADDR_W-1:0]];
	end

	// stage 2: offsets and products
	logic signed [gcs_pkg::DX_W-1:0] dx_c, dy_c, dx_s2, dy_s2;
	logic signed [gcs_pkg::PROD_W-1:0] px_s2, py_s2;
	assign dx_c = signed'(gcs_pkg::DX_W'(rd_s1.col)) - signed'(gcs_pkg::DX_W'(cx_q));
	assign dy_c = signed'(gcs_pkg::DX_W'(rd_s1.row)) - signed'(gcs_pkg::DX_W'(cy_q));
	always_ff @(posedge clk) begin
		dx_s2 <= dx_c;
		dy_s2 <= dy_c;
		px_s2 <= gcs_pkg::PROD_W'(dx_c) * gcs_pkg::PROD_W'(rd_s1.gx);
		py_s2 <= gcs_pkg::PROD_W'(dy_c) * gcs_pkg::PROD_W'(rd_s1.gy);
	end

	// stage 3: dot product and squared distance
	logic signed [gcs_pkg::DOT_W-1:0] dot_c;
	logic signed [gcs_pkg::MAG_W-1:0] mag_c;
	logic [gcs_pkg::DPOS_W-1:0] dot_s3;
	logic [gcs_pkg::MAG_W-1:0] mag_s3;
	logic pos_s3;
	assign dot_c = gcs_pkg::DOT_W'(px_s2) + gcs_pkg::DOT_W'(py_s2);
	assign mag_c = gcs_pkg::MAG_W'(dx_s2) * gcs_pkg::MAG_W'(dx_s2)
		+ gcs_pkg::MAG_W'(dy_s2) * gcs_pkg::MAG_W'(dy_s2);
	always_ff @(posedge clk) begin
		dot_s3 <= dot_c[gcs_pkg::DPOS_W-1:0];
		pos_s3 <= !dot_c[gcs_pkg::DOT_W-1] && (dot_c != '0);
		mag_s3 <= unsigned'(mag_c);
	end

	// stage 4: square of the dot product; non-positive entries add zero
	logic [gcs_pkg::SQ_W-1:0] sq_s4;
	logic [gcs_pkg::MAG_W-1:0] mag_s4;
	always_ff @(posedge clk) begin
		sq_s4 <= pos_s3 ? gcs_pkg::SQ_W'(dot_s3) * gcs_pkg::SQ_W'(dot_s3) : '0;
		mag_s4 <= pos_s3 ? mag_s3 : gcs_pkg::MAG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [gcs_pkg::MAG_W-1:0] rem_d [gcs_pkg::SQ_W];
	logic [gcs_pkg::MAG_W-1:0] div_d [gcs_pkg::SQ_W];
	logic [gcs_pkg::SQ_W-1:0] num_d [gcs_pkg::SQ_W];
	logic [gcs_pkg::SQ_W-1:0] quo_d [gcs_pkg::SQ_W];
	logic [gcs_pkg::MAG_W-1:0] rem_in [gcs_pkg::SQ_W];
	logic [gcs_pkg::MAG_W-1:0] div_in [gcs_pkg::SQ_W];
	logic [gcs_pkg::SQ_W-1:0] num_in [gcs_pkg::SQ_W];
	logic [gcs_pkg::SQ_W-1:0] quo_in [gcs_pkg::SQ_W];
	logic [gcs_pkg::MAG_W:0] trial [gcs_pkg::SQ_W];
	logic [gcs_pkg::SQ_W-1:0] ge;

	// stage inputs and trial subtraction
	always_comb begin
		for (int k = 0; k < gcs_pkg::SQ_W; k++) begin
			if (k == 0) begin
				rem_in[k] = '0;
				div_in[k] = mag_s4;
				num_in[k] = sq_s4;
				quo_in[k] = '0;
			end else begin
				rem_in[k] = rem_d[k-1];
				div_in[k] = div_d[k-1];
				num_in[k] = num_d[k-1];
				quo_in[k] = quo_d[k-1];
			end
			trial[k] = {rem_in[k], num_in[k][gcs_pkg::SQ_W-1]};
			ge[k] = trial[k] >= {1'b0, div_in[k]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < gcs_pkg::SQ_W; k++) begin
			rem_d[k] <= ge[k] ? gcs_pkg::MAG_W'(trial[k] - {1'b0, div_in[k]})
				: trial[k][gcs_pkg::MAG_W-1:0];
			div_d[k] <= div_in[k];
			num_d[k] <= {num_in[k][gcs_pkg::SQ_W-2:0], 1'b0};
			quo_d[k] <= {quo_in[k][gcs_pkg::SQ_W-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= '0;
		else v_d <= {v_d[gcs_pkg::SQ_W-2:0], v_s4};
	end

	// saturating accumulation of quotients
	logic [gcs_pkg::ACC_W-1:0] acc_c;
	assign acc_c = gcs_pkg::ACC_W'(sum_q) + gcs_pkg::ACC_W'(quo_d[gcs_pkg::SQ_W-1]);
	always_ff @(posedge clk) begin
		if (query_acc) sum_q <= '0;
		else if (v_d[gcs_pkg::SQ_W-1])
			sum_q <= (acc_c > gcs_pkg::ACC_W'(gcs_pkg::SCORE_MAX)) ? gcs_pkg::SCORE_MAX
				: acc_c[gcs_pkg::SCORE_W-1:0];
	end

	assign out_ch.valid = (state_q == gcs_pkg::ST_DONE);
	assign out_ch.score = sum_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gcs_pkg::CNT_W'(gcs_pkg::MAX_GRADIENTS))
		else $error("store count beyond capacity");
	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gcs_pkg::ST_WALK) |-> !v_s1 && !v_s4 && !v_d[gcs_pkg::SQ_W-1])
		else $error("walk pipeline active outside a query");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> out_ch.valid && !in_ch.ready)
		else $error("finished walk did not present a result");
endmodule
`default_nettype wire

>>> tb/sv/gcs_checker.sv
// score predictor and result checker for the gradient centre score block
`timescale 1ns / 1ps
module gcs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [gcs_pkg::CFG_W-1:0] cfg_wdata,
	gcs_in_if in_ch,
	gcs_out_if out_ch,
	output int fail_count,
	output int pending_scores
);
	import gcs_pkg::*;

	entry_t grad_mem [MAX_GRADIENTS];
	int unsigned grad_cnt;
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned width_reg;
	int unsigned height_reg;
	logic [SCORE_W-1:0] score_q [$];

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned m);
		if (v == 0) return 1;
		if (v > m) return m;
		return v;
	endfunction

	// walk the stored gradients for one centre
	function automatic logic [SCORE_W-1:0] centre_score(int cx, int cy);
		longint unsigned acc;
		longint dx, dy, dot, mag;
		longint unsigned d;
		acc = 0;
		for (int unsigned i = 0; i < grad_cnt; i++) begin
			dx = longint'(grad_mem[i].col) - cx;
			dy = longint'(grad_mem[i].row) - cy;
			dot = dx * longint'(grad_mem[i].gx) + dy * longint'(grad_mem[i].gy);
			if (dot > 0) begin
				mag = dx * dx + dy * dy;
				if (mag != 0) begin
					d = dot;
					acc += (d * d) / longint'(mag);
					if (acc > SCORE_MAX) acc = SCORE_MAX;
				end
			end
		end
		return acc[SCORE_W-1:0];
	endfunction

	// place one pixel in raster order
	task automatic load_pixel(logic fs, logic signed [GRAD_W-1:0] gx,
		logic signed [GRAD_W-1:0] gy);
		int unsigned w, h;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (fs) begin
			grad_cnt = 0;
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < MAX_HEIGHT) row_pos++;
		end
		if (row_pos >= h) return;
		if ((gx != 0 || gy != 0) && grad_cnt < MAX_GRADIENTS) begin
			grad_mem[grad_cnt] = '{col: col_pos[COL_W-1:0], row: row_pos[ROW_W-1:0],
				gx: gx, gy: gy};
			grad_cnt++;
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < MAX_HEIGHT) row_pos++;
		end
	endtask

	// predict on accepted words, compare on delivered scores
	always @(posedge clk or negedge arst_n) begin
		logic [SCORE_W-1:0] want;
		if (!arst_n) begin
			grad_cnt = 0;
			col_pos = 0;
			row_pos = 0;
			width_reg = 64;
			height_reg = 64;
			fail_count <= 0;
			pending_scores <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) width_reg = cfg_wdata;
				else if (cfg_index == REG_HEIGHT) height_reg = cfg_wdata;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (score_q.size() == 0) begin
					$error("score word with nothing expected: %0d", out_ch.score);
					fail_count <= fail_count + 1;
				end else begin
					want = score_q.pop_front();
					if (out_ch.score !== want) begin
						$error("score expected %0d actual %0d", want, out_ch.score);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.func) score_q.push_back(centre_score(in_ch.center_x, in_ch.center_y));
				else load_pixel(in_ch.frame_start, in_ch.grad_x, in_ch.grad_y);
			end
			pending_scores <= score_q.size();
		end
	end
endmodule

>>> tb/sv/tb_gradient_center_score_core.sv
// testbench top: stimulus, idling and verdict for the gradient centre score block
`timescale 1ns / 1ps
module tb_gradient_center_score_core;
	import gcs_pkg::*;

	localparam int WATCHDOG = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int fail_count;
	int pending_scores;
	int send_idle_pct = 18;
	int recv_idle_pct = 82;
	bit recv_hold = 1'b0;
	int idle_cycles = 0;

	gcs_in_if in_ch ();
	gcs_out_if out_ch ();

	gradient_center_score_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
	);

	gcs_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending_scores(pending_scores)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.frame_start = 1'b0;
		in_ch.grad_x = '0;
		in_ch.grad_y = '0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		out_ch.ready = 1'b0;
	end

	// receiver: random stalls, or a long hold-off
	always @(posedge clk) begin
		if (recv_hold) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one word and hold it until accepted; valid stays high afterwards
	task automatic send_word(logic fn, logic fs, logic signed [GRAD_W-1:0] gx,
		logic signed [GRAD_W-1:0] gy, logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.frame_start <= fs;
		in_ch.grad_x <= gx;
		in_ch.grad_y <= gy;
		in_ch.center_x <= cx;
		in_ch.center_y <= cy;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// stop offering and wait until every expected score has arrived
	task automatic drain_scores();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_scores != 0) @(posedge clk);
		repeat (SQ_W + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [GRAD_W-1:0] rand_grad();
		case ($urandom_range(5))
			0: return 16'sd0;
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'($urandom);
			default: return 16'($signed(17'($urandom_range(32768)) - 17'sd16384));
		endcase
	endfunction

	// a frame of random pixels followed by a few queries
	task automatic random_frame(int npix, int nq);
		logic signed [GRAD_W-1:0] gx, gy;
		for (int i = 0; i < npix; i++) begin
			gx = rand_grad();
			gy = ($urandom_range(3) == 0) ? 16'sd0 : rand_grad();
			send_word(1'b0, (i == 0) || ($urandom_range(40) == 0), gx, gy,
				6'($urandom), 6'($urandom));
		end
		for (int i = 0; i < nq; i++)
			send_word(1'b1, 1'($urandom), rand_grad(), rand_grad(),
				6'($urandom_range(7)), 6'($urandom_range(7)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small frame, extreme gradients
		write_reg(REG_WIDTH, 7'd3);
		write_reg(REG_HEIGHT, 7'd2);
		send_word(1'b0, 1'b1, 16'sd16384, 16'sd0, '0, '0);
		send_word(1'b0, 1'b0, 16'sd0, 16'sd0, '0, '0);
		send_word(1'b0, 1'b0, -16'sd16384, -16'sd16384, '0, '0);
		send_word(1'b0, 1'b0, 16'sd0, 16'sd16384, '0, '0);
		send_word(1'b0, 1'b0, 16'sh7fff, 16'sh8000, '0, '0);
		send_word(1'b0, 1'b0, 16'sd1, -16'sd1, '0, '0);
		// rows past the frame are ignored
		send_word(1'b0, 1'b0, 16'sd5000, 16'sd5000, '0, '0);
		send_word(1'b1, 1'b0, '0, '0, 6'd0, 6'd0);
		send_word(1'b1, 1'b0, '0, '0, 6'd1, 6'd1);
		send_word(1'b1, 1'b1, 16'hffff, 16'hffff, 6'd63, 6'd63);
		send_word(1'b1, 1'b0, '0, '0, 6'd2, 6'd0);
		drain_scores();
		// width shrink mid row, then zero and oversize registers
		write_reg(REG_WIDTH, 7'd64);
		write_reg(REG_HEIGHT, 7'd64);
		send_word(1'b0, 1'b1, 16'sd100, 16'sd200, '0, '0);
		send_word(1'b0, 1'b0, -16'sd300, 16'sd400, '0, '0);
		drain_scores();
		write_reg(REG_WIDTH, 7'd1);
		write_reg(REG_HEIGHT, 7'd0);
		send_word(1'b0, 1'b0, 16'sd16384, 16'sd16384, '0, '0);
		send_word(1'b1, 1'b0, '0, '0, 6'd0, 6'd5);
		drain_scores();
		write_reg(REG_WIDTH, 7'd127);
		write_reg(REG_HEIGHT, 7'd127);
		send_word(1'b0, 1'b1, 16'sd16384, -16'sd16384, '0, '0);
		send_word(1'b0, 1'b0, -16'sd16384, 16'sd16384, '0, '0);
		send_word(1'b1, 1'b0, '0, '0, 6'd63, 6'd0);
		send_word(1'b1, 1'b0, '0, '0, 6'd0, 6'd63);

		// long receiver hold-off while queries keep coming
		recv_hold = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			begin
				send_word(1'b1, 1'b0, '0, '0, 6'd1, 6'd0);
				send_word(1'b1, 1'b0, '0, '0, 6'd2, 6'd2);
				send_word(1'b1, 1'b0, '0, '0, 6'd3, 6'd1);
			end
		join
		drain_scores();

		// random phases over several geometries and idling mixes
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 82 : 0;
			recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 18 : 0;
			for (int f = 0; f < 3; f++) begin
				drain_scores();
				write_reg(REG_WIDTH, 7'($urandom_range(1, 8)));
				write_reg(REG_HEIGHT, 7'($urandom_range(1, 6)));
				random_frame($urandom_range(6, 14), $urandom_range(2, 4));
			end
		end
		drain_scores();

		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
